// ===== src/psa_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// psa_pkg - shared types and constants of the paged slot allocator
// Field widths, request and status codes, register indexes and the
// structs that travel between the allocator's modules.
// ----------------------------------------------------------------------------
package psa_pkg;

	// Field widths fixed by the interface
	localparam int REQ_W      = 2;
	localparam int PAGE_FW    = 3;
	localparam int IDX_W      = 11;
	localparam int STAT_W     = 2;
	localparam int CAP_W      = 12;
	localparam int INIT_W     = 4;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 12;

	// Default sizing
	localparam int MAX_PAGES_DEF = 8;
	localparam int MAX_SLOTS_DEF = 2048;

	// Register reset values
	localparam logic [CAP_W-1:0]  CAP_RESET  = 12'd2048;
	localparam logic [INIT_W-1:0] INIT_RESET = 4'd1;
	localparam logic              GROW_RESET = 1'b0;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_INITIAL  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_GROW     = 2'd2;

	typedef enum logic [REQ_W-1:0] {
		REQ_ALLOC = 2'd0,
		REQ_FREE  = 2'd1,
		REQ_RESET = 2'd2
	} req_t;

	typedef enum logic [STAT_W-1:0] {
		STAT_OK        = 2'd0,
		STAT_FULL      = 2'd1,
		STAT_BAD_PAGE  = 2'd2,
		STAT_OVERFLOW  = 2'd3
	} status_t;

	typedef enum logic {
		ALU_INC = 1'b0,
		ALU_DEC = 1'b1
	} alu_op_t;

	typedef struct packed {
		logic [CAP_W-1:0]  page_capacity;
		logic [INIT_W-1:0] initial_pages;
		logic              grow_enabled;
	} cfg_t;

	typedef struct packed {
		status_t            status;
		logic [PAGE_FW-1:0] slot_page;
		logic [IDX_W-1:0]   slot_index;
	} res_t;

endpackage
`default_nettype wire

// ===== src/psa_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// psa_ram - generic single-port RAM
// One access per cycle, write or read, with registered read data.
// ----------------------------------------------------------------------------
module psa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             en,
	input  wire logic             we,
	input  wire logic [AW-1:0]    addr,
	input  wire logic [WIDTH-1:0] wdata,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write or read one word; hold read data between reads
	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem_q[addr] <= wdata;
			end else begin
				rdata_q <= mem_q[addr];
			end
		end
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire

// ===== src/psa_alu.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// psa_alu - shared increment/decrement and compare unit
// One adder steps a counter up or down; one comparator tests a < b.
// ----------------------------------------------------------------------------
module psa_alu #(
	parameter int W = 12
) (
	input  wire psa_pkg::alu_op_t op,
	input  wire logic [W-1:0]     a,
	input  wire logic [W-1:0]     b,
	output logic      [W-1:0]     res,
	output logic                  lt
);

	// Add one or add all-ones
	assign res = a + ((op == psa_pkg::ALU_DEC) ? {W{1'b1}} : W'(1));

	// Unsigned compare
	assign lt = (a < b);

endmodule
`default_nettype wire

// ===== src/psa_seq.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// psa_seq - allocator sequencer and page state
// Walks each transaction through a few steps, one shared ALU operation per
// step. Holds per-page free-stack depths, bump counters, the usable-page
// stack and the free-slot RAM.
// ----------------------------------------------------------------------------
module psa_seq #(
	parameter int MAX_PAGES = psa_pkg::MAX_PAGES_DEF,
	parameter int MAX_SLOTS = psa_pkg::MAX_SLOTS_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         start,
	input  wire logic [psa_pkg::REQ_W-1:0]    req_type,
	input  wire logic [psa_pkg::PAGE_FW-1:0]  free_page,
	input  wire logic [psa_pkg::IDX_W-1:0]    free_index,
	input  wire psa_pkg::cfg_t                cfg,
	output logic                              busy,
	output logic                              done,
	output psa_pkg::res_t                     res
);

	localparam int PG_W  = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
	localparam int PC_W  = $clog2(MAX_PAGES + 1);
	localparam int SL_W  = $clog2(MAX_SLOTS);
	localparam int SC_W  = $clog2(MAX_SLOTS + 1);
	localparam int W0    = (SC_W > PC_W) ? SC_W : PC_W;
	localparam int W     = (W0 > psa_pkg::PAGE_FW) ? W0 : psa_pkg::PAGE_FW;
	localparam int RAM_AW    = PG_W + SL_W;
	localparam int RAM_DEPTH = 1 << RAM_AW;

	typedef enum logic [14:0] {
		ST_IDLE    = 15'b000000000000001,
		ST_A_GROW  = 15'b000000000000010,
		ST_A_ADD   = 15'b000000000000100,
		ST_A_TOP   = 15'b000000000001000,
		ST_A_SEL   = 15'b000000000010000,
		ST_A_TEST  = 15'b000000000100000,
		ST_A_POP   = 15'b000000001000000,
		ST_A_BUMP  = 15'b000000010000000,
		ST_A_RECHK = 15'b000000100000000,
		ST_F_CHK   = 15'b000001000000000,
		ST_F_CAP   = 15'b000010000000000,
		ST_F_USE   = 15'b000100000000000,
		ST_F_INC   = 15'b001000000000000,
		ST_F_PUSH  = 15'b010000000000000,
		ST_RST     = 15'b100000000000000
	} state_t;

	state_t                         state_q;
	logic                           done_q;
	psa_pkg::res_t                  res_q;
	logic [SC_W-1:0]                depth_q  [MAX_PAGES];
	logic [SC_W-1:0]                bump_q   [MAX_PAGES];
	logic [PG_W-1:0]                ustack_q [MAX_PAGES];
	logic [PC_W-1:0]                udepth_q;
	logic [PC_W-1:0]                pcount_q;
	logic [PG_W-1:0]                p_q;
	logic [PG_W-1:0]                tidx_q;
	logic [psa_pkg::PAGE_FW-1:0]    fpage_q;
	logic [psa_pkg::IDX_W-1:0]      fidx_q;
	logic [psa_pkg::IDX_W-1:0]      bidx_q;
	logic                           from_ram_q;
	logic                           wu_q;

	logic [SC_W-1:0]                cap;
	logic [PC_W-1:0]                init_n;
	logic [SC_W-1:0]                depth_cur;
	logic [SC_W-1:0]                bump_cur;
	psa_pkg::alu_op_t               alu_op;
	logic [W-1:0]                   alu_a;
	logic [W-1:0]                   alu_b;
	logic [W-1:0]                   alu_res;
	logic                           alu_lt;
	logic                           ram_en;
	logic                           ram_we;
	logic [RAM_AW-1:0]              ram_addr;
	logic [psa_pkg::IDX_W-1:0]      ram_rdata;

	// Clamp the capacity and initial page count into range
	always_comb begin
		if (cfg.page_capacity == '0) begin
			cap = SC_W'(1);
		end else if (32'(cfg.page_capacity) > 32'(MAX_SLOTS)) begin
			cap = SC_W'(MAX_SLOTS);
		end else begin
			cap = SC_W'(cfg.page_capacity);
		end
		if (cfg.initial_pages == '0) begin
			init_n = PC_W'(1);
		end else if (32'(cfg.initial_pages) > 32'(MAX_PAGES)) begin
			init_n = PC_W'(MAX_PAGES);
		end else begin
			init_n = PC_W'(cfg.initial_pages);
		end
	end

	assign depth_cur = depth_q[p_q];
	assign bump_cur  = bump_q[p_q];

	// Pick the operands of the shared unit for the current step
	always_comb begin
		alu_op = psa_pkg::ALU_INC;
		alu_a  = '0;
		alu_b  = '0;
		unique case (state_q)
			ST_A_GROW: begin
				alu_a = W'(pcount_q);
				alu_b = W'(MAX_PAGES);
			end
			ST_A_ADD: begin
				alu_a = W'(pcount_q);
			end
			ST_A_TOP: begin
				alu_op = psa_pkg::ALU_DEC;
				alu_a  = W'(udepth_q);
			end
			ST_A_TEST, ST_A_RECHK, ST_F_USE: begin
				alu_a = W'(bump_cur);
				alu_b = W'(cap);
			end
			ST_A_POP: begin
				alu_op = psa_pkg::ALU_DEC;
				alu_a  = W'(depth_cur);
			end
			ST_A_BUMP: begin
				alu_a = W'(bump_cur);
			end
			ST_F_CHK: begin
				alu_a = W'(fpage_q);
				alu_b = W'(pcount_q);
			end
			ST_F_CAP: begin
				alu_a = W'(depth_cur);
				alu_b = W'(cap);
			end
			ST_F_INC: begin
				alu_a = W'(depth_cur);
			end
			ST_F_PUSH: begin
				alu_a = W'(udepth_q);
			end
			default: begin
			end
		endcase
	end

	psa_alu #(
		.W (W)
	) u_alu (
		.op  (alu_op),
		.a   (alu_a),
		.b   (alu_b),
		.res (alu_res),
		.lt  (alu_lt)
	);

	// Read the top of a free stack on pop, write it on free
	assign ram_en   = (state_q == ST_A_POP) || (state_q == ST_F_USE);
	assign ram_we   = (state_q == ST_F_USE);
	assign ram_addr = (state_q == ST_F_USE) ? {p_q, SL_W'(depth_cur)}
	                                        : {p_q, SL_W'(alu_res)};

	psa_ram #(
		.WIDTH (psa_pkg::IDX_W),
		.DEPTH (RAM_DEPTH)
	) u_ram (
		.clk   (clk),
		.en    (ram_en),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (fidx_q),
		.rdata (ram_rdata)
	);

	// Sequencer and page state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			done_q     <= 1'b0;
			res_q      <= '0;
			udepth_q   <= PC_W'(1);
			pcount_q   <= PC_W'(1);
			p_q        <= '0;
			tidx_q     <= '0;
			fpage_q    <= '0;
			fidx_q     <= '0;
			bidx_q     <= '0;
			from_ram_q <= 1'b0;
			wu_q       <= 1'b0;
			for (int i = 0; i < MAX_PAGES; i++) begin
				depth_q[i]  <= '0;
				bump_q[i]   <= '0;
				ustack_q[i] <= PG_W'(i);
			end
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						fpage_q <= free_page;
						fidx_q  <= free_index;
						unique case (req_type)
							psa_pkg::REQ_ALLOC: state_q <= ST_A_GROW;
							psa_pkg::REQ_FREE:  state_q <= ST_F_CHK;
							psa_pkg::REQ_RESET: state_q <= ST_RST;
							default: begin
								done_q <= 1'b1;
								res_q  <= '{psa_pkg::STAT_OK, '0, '0};
							end
						endcase
					end
				end
				ST_A_GROW: begin
					if ((udepth_q == '0) && cfg.grow_enabled && alu_lt) begin
						state_q <= ST_A_ADD;
					end else begin
						state_q <= ST_A_TOP;
					end
				end
				// Add a fresh page and push it onto the empty usable stack
				ST_A_ADD: begin
					depth_q[PG_W'(pcount_q)] <= '0;
					bump_q[PG_W'(pcount_q)]  <= '0;
					ustack_q[0]              <= PG_W'(pcount_q);
					udepth_q                 <= PC_W'(1);
					pcount_q                 <= PC_W'(alu_res);
					state_q                  <= ST_A_TOP;
				end
				ST_A_TOP: begin
					tidx_q <= PG_W'(alu_res);
					if (udepth_q == '0) begin
						done_q  <= 1'b1;
						res_q   <= '{psa_pkg::STAT_FULL, '0, '0};
						state_q <= ST_IDLE;
					end else begin
						state_q <= ST_A_SEL;
					end
				end
				ST_A_SEL: begin
					p_q     <= ustack_q[tidx_q];
					state_q <= ST_A_TEST;
				end
				// Drop a stale top page, else choose free stack or bump counter
				ST_A_TEST: begin
					if ((depth_cur == '0) && !alu_lt) begin
						udepth_q <= PC_W'(tidx_q);
						done_q   <= 1'b1;
						res_q    <= '{psa_pkg::STAT_FULL, '0, '0};
						state_q  <= ST_IDLE;
					end else if (depth_cur != '0) begin
						state_q <= ST_A_POP;
					end else begin
						state_q <= ST_A_BUMP;
					end
				end
				ST_A_POP: begin
					depth_q[p_q] <= SC_W'(alu_res);
					from_ram_q   <= 1'b1;
					state_q      <= ST_A_RECHK;
				end
				ST_A_BUMP: begin
					bump_q[p_q] <= SC_W'(alu_res);
					bidx_q      <= psa_pkg::IDX_W'(bump_cur);
					from_ram_q  <= 1'b0;
					state_q     <= ST_A_RECHK;
				end
				// Pop the page once it is full and report the slot
				ST_A_RECHK: begin
					if ((depth_cur == '0) && !alu_lt) begin
						udepth_q <= PC_W'(tidx_q);
					end
					done_q  <= 1'b1;
					res_q   <= '{psa_pkg::STAT_OK, psa_pkg::PAGE_FW'(p_q),
					             from_ram_q ? ram_rdata : bidx_q};
					state_q <= ST_IDLE;
				end
				ST_F_CHK: begin
					p_q <= PG_W'(fpage_q);
					if (!alu_lt) begin
						done_q  <= 1'b1;
						res_q   <= '{psa_pkg::STAT_BAD_PAGE, '0, '0};
						state_q <= ST_IDLE;
					end else begin
						state_q <= ST_F_CAP;
					end
				end
				ST_F_CAP: begin
					if (!alu_lt) begin
						done_q  <= 1'b1;
						res_q   <= '{psa_pkg::STAT_OVERFLOW, '0, '0};
						state_q <= ST_IDLE;
					end else begin
						state_q <= ST_F_USE;
					end
				end
				ST_F_USE: begin
					wu_q    <= (depth_cur != '0) || alu_lt;
					state_q <= ST_F_INC;
				end
				ST_F_INC: begin
					depth_q[p_q] <= SC_W'(alu_res);
					if (!wu_q && (udepth_q != PC_W'(MAX_PAGES))) begin
						state_q <= ST_F_PUSH;
					end else begin
						done_q  <= 1'b1;
						res_q   <= '{psa_pkg::STAT_OK, '0, '0};
						state_q <= ST_IDLE;
					end
				end
				// Page became usable again: push it back
				ST_F_PUSH: begin
					ustack_q[PG_W'(udepth_q)] <= p_q;
					udepth_q                  <= PC_W'(alu_res);
					done_q                    <= 1'b1;
					res_q                     <= '{psa_pkg::STAT_OK, '0, '0};
					state_q                   <= ST_IDLE;
				end
				// Empty every page and rebuild the usable stack
				ST_RST: begin
					for (int i = 0; i < MAX_PAGES; i++) begin
						depth_q[i]  <= '0;
						bump_q[i]   <= '0;
						ustack_q[i] <= PG_W'(i);
					end
					udepth_q <= init_n;
					pcount_q <= init_n;
					done_q   <= 1'b1;
					res_q    <= '{psa_pkg::STAT_OK, '0, '0};
					state_q  <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign busy = (state_q != ST_IDLE);
	assign done = done_q;
	assign res  = res_q;

endmodule
`default_nettype wire

// ===== src/paged_slot_allocator.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// paged_slot_allocator - paged slot allocator with free stacks and bump counters
// Allocates and frees slots over a set of pages. Each page serves slots from
// its LIFO free stack first, then from its bump counter; a stack of usable
// pages picks the page for each allocation.
//
//   channel   handshake             payload
//   --------  --------------------  -----------------------------------------
//   request   start & !busy         req_type, free_page, free_index
//   result    done (one cycle)      status, slot_page, slot_index
//   config    cfg_valid & cfg_ready cfg_index, cfg_data
//
// A transaction occupies the block from its start until its done cycle, in
// which the next start is taken. One shared add/compare unit does one step
// per cycle; each allocation, free, allocator reset or unused request code
// runs as its own sequence of steps, ending early on an error. The result
// cannot be stalled.
// After reset one page is present, all free stacks empty; no clearing pass.
// ----------------------------------------------------------------------------
module paged_slot_allocator #(
	parameter int MAX_PAGES = psa_pkg::MAX_PAGES_DEF,
	parameter int MAX_SLOTS = psa_pkg::MAX_SLOTS_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            start,
	output logic                                 busy,
	input  wire logic [psa_pkg::REQ_W-1:0]       req_type,
	input  wire logic [psa_pkg::PAGE_FW-1:0]     free_page,
	input  wire logic [psa_pkg::IDX_W-1:0]       free_index,
	output logic                                 done,
	output logic [psa_pkg::STAT_W-1:0]           status,
	output logic [psa_pkg::PAGE_FW-1:0]          slot_page,
	output logic [psa_pkg::IDX_W-1:0]            slot_index,
	input  wire logic                            cfg_valid,
	output logic                                 cfg_ready,
	input  wire logic [psa_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [psa_pkg::CFG_DATA_W-1:0]  cfg_data
);

	psa_pkg::cfg_t cfg_q;
	psa_pkg::res_t res;

	assign cfg_ready = 1'b1;

	// Decode configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.page_capacity <= psa_pkg::CAP_RESET;
			cfg_q.initial_pages <= psa_pkg::INIT_RESET;
			cfg_q.grow_enabled  <= psa_pkg::GROW_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				psa_pkg::CFG_CAPACITY:
					cfg_q.page_capacity <= cfg_data[psa_pkg::CAP_W-1:0];
				psa_pkg::CFG_INITIAL:
					cfg_q.initial_pages <= cfg_data[psa_pkg::INIT_W-1:0];
				psa_pkg::CFG_GROW:
					cfg_q.grow_enabled  <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	psa_seq #(
		.MAX_PAGES (MAX_PAGES),
		.MAX_SLOTS (MAX_SLOTS)
	) u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.req_type   (req_type),
		.free_page  (free_page),
		.free_index (free_index),
		.cfg        (cfg_q),
		.busy       (busy),
		.done       (done),
		.res        (res)
	);

	assign status     = res.status;
	assign slot_page  = res.slot_page;
	assign slot_index = res.slot_index;

endmodule
`default_nettype wire

// ===== src/psa_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// psa_checker - port-level checks of the paged slot allocator
// Watches the request and result ports over time; bound to the top level.
// ----------------------------------------------------------------------------
module psa_checker (
	input wire logic                            clk,
	input wire logic                            arst_n,
	input wire logic                            start,
	input wire logic                            busy,
	input wire logic                            done,
	input wire logic [psa_pkg::STAT_W-1:0]      status,
	input wire logic [psa_pkg::PAGE_FW-1:0]     slot_page,
	input wire logic [psa_pkg::IDX_W-1:0]       slot_index
);

	// An accepted transaction either finishes at once or keeps the block busy
	a_accept_progress: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy || done)
		else $error("accepted transaction neither busy nor done");

	// A result is shown only once the block is free again
	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while busy");

	// Every result belongs to a transaction in flight or just accepted
	a_done_has_source: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy || start))
		else $error("result strobe without a transaction");

	// Failed results carry a zero slot; non-allocating OK results are not checked
	a_error_zero_slot: assert property (@(posedge clk) disable iff (!arst_n)
		done && (status != psa_pkg::STAT_OK) |-> (slot_page == '0) && (slot_index == '0))
		else $error("error result with nonzero slot");

endmodule

bind paged_slot_allocator psa_checker u_psa_checker (.*);
`default_nettype wire
